[rtl/stt_pkg.sv]
// Shared types, codes and helpers for the source text tokenizer.
// No dependencies; every other file in rtl/ uses this package.
package stt_pkg;

    localparam int NUMBER_BITS_DEF = 31;
    localparam int VALUE_W         = 31;
    localparam int Q_DEPTH         = 2;
    localparam int Q_PTR_W         = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_STR  = 2'd2,
        MODE_ID   = 2'd3
    } scan_mode_t;

    localparam logic [3:0] KIND_NUM   = 4'd0;
    localparam logic [3:0] KIND_STR   = 4'd1;
    localparam logic [3:0] KIND_ID    = 4'd2;
    localparam logic [3:0] KIND_KW    = 4'd3;
    localparam logic [3:0] KIND_PLUS  = 4'd4;
    localparam logic [3:0] KIND_MINUS = 4'd5;
    localparam logic [3:0] KIND_MULT  = 4'd6;
    localparam logic [3:0] KIND_DIV   = 4'd7;
    localparam logic [3:0] KIND_SEMI  = 4'd8;
    localparam logic [3:0] KIND_CHAR  = 4'd9;

    // keyword match progress: characters matched, or dead once it cannot match
    localparam logic [2:0] KW_LEN  = 3'd3;
    localparam logic [2:0] KW_DEAD = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte_in;
        logic       end_of_text;
    } stt_in_t;

    typedef struct packed {
        logic [3:0]         token_kind;
        logic [VALUE_W-1:0] number_value;
        logic [7:0]         text_char;
        logic               number_overflow;
        logic               last_of_item;
    } stt_out_t;

    // all results of one input byte
    typedef struct packed {
        logic     two;
        stt_out_t res_a;
        stt_out_t res_b;
    } stt_entry_t;

    typedef struct packed {
        logic       valid;
        stt_entry_t entry;
    } stt_push_t;

    typedef struct packed {
        logic       empty;
        stt_entry_t head;
    } stt_head_t;

    function automatic logic [7:0] kw_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h6C;  // l
            2'd1:    ch = 8'h65;  // e
            2'd2:    ch = 8'h74;  // t
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic stt_out_t mk_result(
        input logic [3:0]         kind,
        input logic [VALUE_W-1:0] value,
        input logic [7:0]         ch,
        input logic               ovf
    );
        stt_out_t r;
        r.token_kind      = kind;
        r.number_value    = value;
        r.text_char       = ch;
        r.number_overflow = ovf;
        r.last_of_item    = 1'b0;
        return r;
    endfunction

endpackage

[rtl/stt_front.sv]
// Front end: accepts text bytes, runs the scanner state and forms the
// results of each byte as one queue entry. Depends on stt_pkg.
module stt_front #(
    parameter int NUMBER_BITS = stt_pkg::NUMBER_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  stt_pkg::stt_in_t  in_data,
    input  logic              full,
    output stt_pkg::stt_push_t push
);

    localparam int AW = NUMBER_BITS + 4;
    localparam logic [NUMBER_BITS-1:0] ACC_MAX = '1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    stt_pkg::scan_mode_t    mode_reg, mode_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic                   sat_reg, sat_next;
    logic [2:0]             kwp_reg, kwp_next;

    logic                   accept;
    logic [7:0]             c;
    logic                   is_digit, is_alpha, is_word;
    logic                   op_hit;
    logic [3:0]             op_kind;
    logic [AW-1:0]          acc_x10;
    logic                   grow;
    logic                   to_idle;
    logic [1:0]             cnt;
    stt_pkg::stt_out_t      tok, res_a, res_b;

    function automatic logic [stt_pkg::VALUE_W-1:0] to_value(
        input logic [NUMBER_BITS-1:0] a
    );
        logic [NUMBER_BITS+stt_pkg::VALUE_W-1:0] w;
        w = {{stt_pkg::VALUE_W{1'b0}}, a};
        return w[stt_pkg::VALUE_W-1:0];
    endfunction

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign c        = in_data.text_byte_in;

    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_alpha = ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
    assign is_word  = is_alpha || is_digit || (c == CH_UNDER);

    // acc * 10 + digit; any bit above the accumulator means overflow
    assign acc_x10 = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1) + AW'(c[3:0]);
    assign grow    = |acc_x10[AW-1:NUMBER_BITS];

    always_comb
    begin
        op_hit  = 1'b1;
        op_kind = stt_pkg::KIND_PLUS;
        unique case (c)
            CH_PLUS:  op_kind = stt_pkg::KIND_PLUS;
            CH_MINUS: op_kind = stt_pkg::KIND_MINUS;
            CH_STAR:  op_kind = stt_pkg::KIND_MULT;
            CH_SLASH: op_kind = stt_pkg::KIND_DIV;
            CH_SEMI:  op_kind = stt_pkg::KIND_SEMI;
            default:  op_hit  = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        sat_next  = sat_reg;
        kwp_next  = kwp_reg;
        res_a     = '0;
        res_b     = '0;
        tok       = '0;
        cnt       = 2'd0;
        to_idle   = 1'b0;

        // high bytes leave the scanner untouched
        if (!c[7])
        begin
            unique case (mode_reg)
                stt_pkg::MODE_NUM:
                begin
                    if (is_digit)
                    begin
                        if (sat_reg || grow)
                        begin
                            acc_next = ACC_MAX;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = acc_x10[NUMBER_BITS-1:0];
                        end
                    end
                    else
                    begin
                        tok = stt_pkg::mk_result(stt_pkg::KIND_NUM, to_value(acc_reg),
                                                 8'h00, sat_reg);
                        if (cnt == 2'd0) res_a = tok; else res_b = tok;
                        cnt       = cnt + 2'd1;
                        mode_next = stt_pkg::MODE_IDLE;
                        acc_next  = '0;
                        sat_next  = 1'b0;
                        kwp_next  = 3'd0;
                        to_idle   = 1'b1;
                    end
                end
                stt_pkg::MODE_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        tok = stt_pkg::mk_result(stt_pkg::KIND_STR, '0, 8'h00, 1'b0);
                        mode_next = stt_pkg::MODE_IDLE;
                        acc_next  = '0;
                        sat_next  = 1'b0;
                        kwp_next  = 3'd0;
                    end
                    else
                    begin
                        tok = stt_pkg::mk_result(stt_pkg::KIND_CHAR, '0, c, 1'b0);
                    end
                    if (cnt == 2'd0) res_a = tok; else res_b = tok;
                    cnt = cnt + 2'd1;
                end
                stt_pkg::MODE_ID:
                begin
                    if (is_word)
                    begin
                        if ((kwp_reg < stt_pkg::KW_LEN) && (c == stt_pkg::kw_char(kwp_reg[1:0])))
                            kwp_next = kwp_reg + 3'd1;
                        else
                            kwp_next = stt_pkg::KW_DEAD;
                        tok = stt_pkg::mk_result(stt_pkg::KIND_CHAR, '0, c, 1'b0);
                        if (cnt == 2'd0) res_a = tok; else res_b = tok;
                        cnt = cnt + 2'd1;
                    end
                    else
                    begin
                        tok = stt_pkg::mk_result((kwp_reg == stt_pkg::KW_LEN) ?
                                                 stt_pkg::KIND_KW : stt_pkg::KIND_ID,
                                                 '0, 8'h00, 1'b0);
                        if (cnt == 2'd0) res_a = tok; else res_b = tok;
                        cnt       = cnt + 2'd1;
                        mode_next = stt_pkg::MODE_IDLE;
                        acc_next  = '0;
                        sat_next  = 1'b0;
                        kwp_next  = 3'd0;
                        to_idle   = 1'b1;
                    end
                end
                stt_pkg::MODE_IDLE:
                begin
                    to_idle = 1'b1;
                end
                default:
                begin
                    to_idle = 1'b1;
                end
            endcase
        end

        // start a new token; whitespace and unknown characters drop out here
        if (to_idle)
        begin
            if (is_digit)
            begin
                mode_next = stt_pkg::MODE_NUM;
                acc_next  = NUMBER_BITS'(c[3:0]);
                sat_next  = 1'b0;
            end
            else if (c == CH_QUOTE)
            begin
                mode_next = stt_pkg::MODE_STR;
            end
            else if (is_alpha || (c == CH_UNDER))
            begin
                mode_next = stt_pkg::MODE_ID;
                kwp_next  = (c == stt_pkg::kw_char(2'd0)) ? 3'd1 : stt_pkg::KW_DEAD;
                tok = stt_pkg::mk_result(stt_pkg::KIND_CHAR, '0, c, 1'b0);
                if (cnt == 2'd0) res_a = tok; else res_b = tok;
                cnt = cnt + 2'd1;
            end
            else if (op_hit)
            begin
                tok = stt_pkg::mk_result(op_kind, '0, 8'h00, 1'b0);
                if (cnt == 2'd0) res_a = tok; else res_b = tok;
                cnt = cnt + 2'd1;
            end
        end

        // flush the pending token after the last byte
        if (in_data.end_of_text)
        begin
            unique case (mode_next)
                stt_pkg::MODE_NUM:
                begin
                    tok = stt_pkg::mk_result(stt_pkg::KIND_NUM, to_value(acc_next),
                                             8'h00, sat_next);
                    if (cnt == 2'd0) res_a = tok; else res_b = tok;
                    cnt = cnt + 2'd1;
                end
                stt_pkg::MODE_STR:
                begin
                    tok = stt_pkg::mk_result(stt_pkg::KIND_STR, '0, 8'h00, 1'b0);
                    if (cnt == 2'd0) res_a = tok; else res_b = tok;
                    cnt = cnt + 2'd1;
                end
                stt_pkg::MODE_ID:
                begin
                    if (cnt == 2'd2)
                    begin
                        // number, char and identifier would not fit: fold the char
                        res_b = stt_pkg::mk_result(stt_pkg::KIND_ID, '0, res_b.text_char, 1'b0);
                    end
                    else
                    begin
                        tok = stt_pkg::mk_result((kwp_next == stt_pkg::KW_LEN) ?
                                                 stt_pkg::KIND_KW : stt_pkg::KIND_ID,
                                                 '0, 8'h00, 1'b0);
                        if (cnt == 2'd0) res_a = tok; else res_b = tok;
                        cnt = cnt + 2'd1;
                    end
                end
                stt_pkg::MODE_IDLE:
                begin
                end
                default:
                begin
                end
            endcase
            mode_next = stt_pkg::MODE_IDLE;
            acc_next  = '0;
            sat_next  = 1'b0;
            kwp_next  = 3'd0;
        end

        if (cnt == 2'd1)
            res_a.last_of_item = 1'b1;
        else if (cnt == 2'd2)
            res_b.last_of_item = 1'b1;
    end

    assign push.valid       = accept && (cnt != 2'd0);
    assign push.entry.two   = (cnt == 2'd2);
    assign push.entry.res_a = res_a;
    assign push.entry.res_b = res_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= stt_pkg::MODE_IDLE;
            acc_reg  <= '0;
            sat_reg  <= 1'b0;
            kwp_reg  <= 3'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            sat_reg  <= sat_next;
            kwp_reg  <= kwp_next;
        end
    end

`ifndef SYNTH
    a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (acc_reg == ACC_MAX))
        else $error("saturated number is not at its maximum");

    a_kw_only_in_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == stt_pkg::MODE_ID) == (kwp_reg != 3'd0))
        else $error("keyword progress out of step with identifier mode");

    a_kw_range: assert property (@(posedge clk) disable iff (!rst_n)
        kwp_reg <= stt_pkg::KW_DEAD)
        else $error("keyword progress beyond dead code");
`endif

endmodule

[rtl/stt_queue.sv]
// Two-entry queue of per-byte result groups between front and back end.
// Depends on stt_pkg.
module stt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  stt_pkg::stt_push_t push,
    output logic               full,
    input  logic               pop,
    output stt_pkg::stt_head_t head
);

    localparam logic [stt_pkg::Q_PTR_W:0] DEPTH = (stt_pkg::Q_PTR_W + 1)'(stt_pkg::Q_DEPTH);
    localparam logic [stt_pkg::Q_PTR_W:0]   COUNT_ONE = (stt_pkg::Q_PTR_W + 1)'(1);
    localparam logic [stt_pkg::Q_PTR_W-1:0] PTR_ONE   = stt_pkg::Q_PTR_W'(1);

    stt_pkg::stt_entry_t           mem_reg [stt_pkg::Q_DEPTH];
    logic [stt_pkg::Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [stt_pkg::Q_PTR_W:0]     count_reg, count_next;
    logic                          do_push, do_pop;

    assign full       = (count_reg == DEPTH);
    assign head.empty = (count_reg == '0);
    assign head.head  = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && !head.empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + COUNT_ONE;
        else if (do_pop && !do_push)
            count_next = count_reg - COUNT_ONE;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_ONE;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_ONE;
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= DEPTH) && ((count_reg == '0) || (count_reg == DEPTH) ||
                                 (wr_ptr_reg != rd_ptr_reg)))
        else $error("queue count out of step with pointers");
`endif

endmodule

[rtl/stt_back.sv]
// Back end: walks each queued result group one result at a time into the
// output register. Depends on stt_pkg.
module stt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  stt_pkg::stt_head_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output stt_pkg::stt_out_t  out_data
);

    stt_pkg::stt_out_t out_reg;
    logic              out_valid_reg;
    logic              half_reg, half_next;
    logic              load;

    // reload whenever the register is empty or its transfer completes
    assign load = !out_valid_reg || !out_stall;
    assign pop  = load && !head.empty && (half_reg || !head.head.two);

    always_comb
    begin
        half_next = half_reg;
        if (load && !head.empty)
            half_next = !pop;
    end

    always_ff @(posedge clk)
    begin
        if (load && !head.empty)
            out_reg <= half_reg ? head.head.res_b : head.head.res_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= !head.empty;
            half_reg <= half_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_half_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (out_valid_reg && !head.empty && head.head.two))
        else $error("second result pending without a two-result entry");
`endif

endmodule

[rtl/source_text_tokenizer.sv]
// Source text tokenizer, top level. The results of a byte, if any, are written into
// the two-entry queue when the byte is transferred and pass from there into the
// output register. One byte per cycle while the queue is not full; a byte with
// two results passes through the single output register one result at a time.
// Reset (rst_n low, asynchronous) returns the scanner to idle, empties the two-entry
// queue and drops out_valid. Depends on stt_pkg, stt_front, stt_queue and stt_back.
module source_text_tokenizer #(
    parameter int NUMBER_BITS = stt_pkg::NUMBER_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  stt_pkg::stt_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output stt_pkg::stt_out_t out_data
);

    stt_pkg::stt_push_t push;
    stt_pkg::stt_head_t head;
    logic               full;
    logic               pop;

    stt_front #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .full     (full),
        .push     (push)
    );

    stt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pop   (pop),
        .head  (head)
    );

    stt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[verif/source_text_tokenizer_tb.sv]
// Self-checking testbench for source_text_tokenizer: directed and random source text,
// with its own token predictor and a scoreboard checking every output transfer in order.
// Depends on stt_pkg and the RTL of source_text_tokenizer.
module source_text_tokenizer_tb;

    class token_checker;
        stt_pkg::stt_out_t   tokens_due[$];
        stt_pkg::stt_out_t   byte_tokens[$];
        stt_pkg::scan_mode_t mode;
        longint unsigned     acc;
        bit                  sat;
        logic [2:0]          kw_prog;
        logic [23:0]         keyword_text;
        longint unsigned     value_max;
        int                  errors;
        int                  checked;
        int                  saturated;
        int                  keywords;

        function new();
            keyword_text = "let";
            value_max    = (64'd1 << stt_pkg::NUMBER_BITS_DEF) - 1;
            clear_scan();
        endfunction

        function void clear_scan();
            mode    = stt_pkg::MODE_IDLE;
            acc     = 0;
            sat     = 1'b0;
            kw_prog = '0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_word(logic [7:0] c);
            return is_alpha(c) || is_digit(c) || c == "_";
        endfunction

        function bit is_space(logic [7:0] c);
            return c == " " || (c >= 8'd9 && c <= 8'd13);
        endfunction

        // at most two results per byte; later ones are dropped
        function void emit(logic [3:0] kind, longint unsigned val, logic [7:0] ch, bit ovf);
            stt_pkg::stt_out_t t;
            if (byte_tokens.size() >= 2)
                return;
            t.token_kind      = kind;
            t.number_value    = val[stt_pkg::VALUE_W-1:0];
            t.text_char       = ch;
            t.number_overflow = ovf;
            t.last_of_item    = 1'b0;
            byte_tokens.push_back(t);
        endfunction

        function void close_number();
            if (sat)
                saturated++;
            emit(stt_pkg::KIND_NUM, acc, 8'h00, sat);
            clear_scan();
        endfunction

        function void close_ident();
            logic [7:0] ch;
            if (byte_tokens.size() >= 2)
            begin
                // no room left: fold the pending char into the identifier token
                ch = byte_tokens[1].text_char;
                void'(byte_tokens.pop_back());
                emit(stt_pkg::KIND_ID, 0, ch, 1'b0);
            end
            else if (kw_prog == stt_pkg::KW_LEN)
            begin
                keywords++;
                emit(stt_pkg::KIND_KW, 0, 8'h00, 1'b0);
            end
            else
                emit(stt_pkg::KIND_ID, 0, 8'h00, 1'b0);
            clear_scan();
        endfunction

        function void word_char(logic [7:0] c);
            if (kw_prog < stt_pkg::KW_LEN && c == keyword_text[23 - 8 * int'(kw_prog) -: 8])
                kw_prog = kw_prog + 3'd1;
            else
                kw_prog = stt_pkg::KW_DEAD;
            emit(stt_pkg::KIND_CHAR, 0, c, 1'b0);
        endfunction

        function void start_token(logic [7:0] c);
            if (is_space(c))
                return;
            if (is_digit(c))
            begin
                mode = stt_pkg::MODE_NUM;
                acc  = c - 8'h30;
                sat  = 1'b0;
                return;
            end
            if (c == "\"")
            begin
                mode = stt_pkg::MODE_STR;
                return;
            end
            if (is_alpha(c) || c == "_")
            begin
                mode    = stt_pkg::MODE_ID;
                kw_prog = '0;
                word_char(c);
                return;
            end
            case (c)
                "+":     emit(stt_pkg::KIND_PLUS, 0, 8'h00, 1'b0);
                "-":     emit(stt_pkg::KIND_MINUS, 0, 8'h00, 1'b0);
                "*":     emit(stt_pkg::KIND_MULT, 0, 8'h00, 1'b0);
                "/":     emit(stt_pkg::KIND_DIV, 0, 8'h00, 1'b0);
                ";":     emit(stt_pkg::KIND_SEMI, 0, 8'h00, 1'b0);
                default: ;
            endcase
        endfunction

        function void note_byte(stt_pkg::stt_in_t b);
            logic [7:0]        c;
            longint unsigned   d;
            stt_pkg::stt_out_t t;
            c = b.text_byte_in;
            byte_tokens.delete();
            if (c < 8'd128)
            begin
                case (mode)
                    stt_pkg::MODE_NUM:
                        if (is_digit(c))
                        begin
                            d = c - 8'h30;
                            if (sat || acc > (value_max - d) / 10)
                            begin
                                acc = value_max;
                                sat = 1'b1;
                            end
                            else
                                acc = acc * 10 + d;
                        end
                        else
                        begin
                            close_number();
                            start_token(c);
                        end
                    stt_pkg::MODE_STR:
                        if (c == "\"")
                        begin
                            emit(stt_pkg::KIND_STR, 0, 8'h00, 1'b0);
                            clear_scan();
                        end
                        else
                            emit(stt_pkg::KIND_CHAR, 0, c, 1'b0);
                    stt_pkg::MODE_ID:
                        if (is_word(c))
                            word_char(c);
                        else
                        begin
                            close_ident();
                            start_token(c);
                        end
                    default:
                        start_token(c);
                endcase
            end
            if (b.end_of_text)
            begin
                case (mode)
                    stt_pkg::MODE_NUM: close_number();
                    stt_pkg::MODE_STR: emit(stt_pkg::KIND_STR, 0, 8'h00, 1'b0);
                    stt_pkg::MODE_ID:  close_ident();
                    default:           ;
                endcase
                clear_scan();
            end
            if (byte_tokens.size() > 0)
            begin
                t = byte_tokens[byte_tokens.size() - 1];
                t.last_of_item = 1'b1;
                byte_tokens[byte_tokens.size() - 1] = t;
            end
            foreach (byte_tokens[i])
                tokens_due.push_back(byte_tokens[i]);
        endfunction

        task report(string what);
            errors++;
            $display("%0t: %s", $time, what);
        endtask

        task check_result(stt_pkg::stt_out_t got);
            stt_pkg::stt_out_t want;
            if (tokens_due.size() == 0)
            begin
                report($sformatf("unexpected result, kind %0d", got.token_kind));
                return;
            end
            want = tokens_due.pop_front();
            checked++;
            if (got.token_kind != want.token_kind)
                report($sformatf("result %0d: token_kind %0d, expected %0d",
                                 checked, got.token_kind, want.token_kind));
            if (got.number_value != want.number_value)
                report($sformatf("result %0d: number_value %0d, expected %0d",
                                 checked, got.number_value, want.number_value));
            if (got.text_char != want.text_char)
                report($sformatf("result %0d: text_char 0x%h, expected 0x%h",
                                 checked, got.text_char, want.text_char));
            if (got.number_overflow != want.number_overflow)
                report($sformatf("result %0d: number_overflow %0d, expected %0d",
                                 checked, got.number_overflow, want.number_overflow));
            if (got.last_of_item != want.last_of_item)
                report($sformatf("result %0d: last_of_item %0d, expected %0d",
                                 checked, got.last_of_item, want.last_of_item));
        endtask
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    stt_pkg::stt_in_t  in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    stt_pkg::stt_out_t out_data;

    token_checker     sb = new();
    stt_pkg::stt_in_t text_q[$];
    bit               quiet_run = 1'b0;
    bit               hold_req  = 1'b0;
    int               bytes_sent = 0;

    always #5 clk = ~clk;

    source_text_tokenizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    function automatic bit take_break();
        return !quiet_run && ($urandom_range(99) < 11);
    endfunction

    function automatic void add_byte(logic [7:0] b, bit eot);
        stt_pkg::stt_in_t t;
        t.text_byte_in = b;
        t.end_of_text  = eot;
        text_q.push_back(t);
    endfunction

    function automatic void add_text(string s, bit eot);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], eot && i == s.len() - 1);
    endfunction

    function automatic void mark_end();
        stt_pkg::stt_in_t t;
        t = text_q.pop_back();
        t.end_of_text = 1'b1;
        text_q.push_back(t);
    endfunction

    function automatic logic [7:0] random_word_char(bit lead);
        int unsigned r;
        r = $urandom_range(lead ? 52 : 62);
        if (r < 26)
            return 8'(97 + r);
        if (r < 52)
            return 8'(65 + r - 26);
        if (r == 52)
            return "_";
        return 8'(48 + r - 53);
    endfunction

    // one well-formed token, or noise, followed by an optional separator or end of text
    function automatic void queue_random_token();
        int unsigned pick;
        int unsigned len;
        logic [7:0]  b;
        string       ops;
        string       blanks;
        ops    = "+-*/;";
        blanks = " \t\n\013\014\r";
        pick   = $urandom_range(99);
        if (pick < 25)
        begin
            if ($urandom_range(11) == 0)
            begin
                if ($urandom_range(1))
                    add_text("2147483647", 1'b0);
                else
                    add_text("2147483648", 1'b0);
            end
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 10) : $urandom_range(4, 1);
                repeat (len)
                    add_byte(8'(48 + $urandom_range(9)), 1'b0);
            end
            // letter or underscore closing a number on the last byte
            if ($urandom_range(9) == 0)
                add_byte(random_word_char(1'b1), 1'b1);
        end
        else if (pick < 50)
        begin
            case ($urandom_range(7))
                0, 1:    add_text("let", 1'b0);
                2:       add_text("le", 1'b0);
                3:       add_text("lets", 1'b0);
                default:
                begin
                    add_byte(random_word_char(1'b1), 1'b0);
                    repeat ($urandom_range(5))
                        add_byte(random_word_char(1'b0), 1'b0);
                end
            endcase
        end
        else if (pick < 65)
        begin
            add_byte("\"", 1'b0);
            repeat ($urandom_range(5))
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == "\"");
                add_byte(b, 1'b0);
            end
            if ($urandom_range(4) == 0)
                mark_end();
            else
                add_byte("\"", 1'b0);
        end
        else if (pick < 80)
            add_byte(ops[$urandom_range(4)], 1'b0);
        else if (pick < 92)
            add_byte(blanks[$urandom_range(5)], 1'b0);
        else
            add_byte(8'($urandom_range(255)), $urandom_range(3) == 0);

        if ($urandom_range(11) == 0)
            mark_end();
        else if ($urandom_range(1))
            add_byte(" ", 1'b0);
    endfunction

    task automatic send_byte(input stt_pkg::stt_in_t b);
        @(negedge clk);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.tokens_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver: random stalls, or a long hold-off on request
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (80) @(negedge clk);
            end
            out_stall <= take_break();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    initial
    begin
        stt_pkg::stt_in_t item;
        int               counted;
        int               drained_at;
        bit               hold_done;
        counted    = 0;
        drained_at = -1;
        hold_done  = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // keyword, high byte in a string, crowded end, flush by a high byte,
        // lone quote at end, unterminated string, operators, ignored bytes
        add_text("let ", 1'b0);
        add_text("\"a", 1'b0);
        add_byte(8'hFF, 1'b0);
        add_text("\"", 1'b0);
        add_text("7a", 1'b1);
        add_text("x", 1'b0);
        add_byte(8'hC8, 1'b1);
        add_text("\"", 1'b1);
        add_text("\"b", 1'b1);
        add_text("+-*/;", 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h09, 1'b0);
        add_byte(8'h0D, 1'b0);
        add_text("_", 1'b1);
        while (text_q.size() != 0)
            send_byte(text_q.pop_front());
        wait_for_results();

        while (counted < 600)
        begin
            if (text_q.size() == 0)
                queue_random_token();
            item = text_q.pop_front();
            send_byte(item);
            counted++;
            // back up the output while input keeps coming
            if (counted == 100 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            quiet_run = (counted >= 250 && counted < 350);
            if ((counted == 200 || counted == 450) && drained_at != counted)
            begin
                drained_at = counted;
                wait_for_results();
            end
        end
        while (text_q.size() != 0)
            send_byte(text_q.pop_front());

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.tokens_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d byte transfers and %0d checked results,", bytes_sent,
                 sb.checked);
        $display("with %0d saturated numbers and %0d keywords among them.", sb.saturated,
                 sb.keywords);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results still outstanding", sb.tokens_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
